// File: rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// shared constants, types and the month length table of the timestamp parser
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int CHAR_W   = 8;
   localparam int POS_W    = 5;
   localparam int YEAR_W   = 14;
   localparam int ACC_W    = 7;
   localparam int DIGIT_W  = 4;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int RSP_DATA_W = 40;

   // text layout YYYY-MM-DD/HH:MM
   localparam logic [POS_W-1:0] TEXT_LEN     = 5'd16;
   localparam logic [POS_W-1:0] POS_SAT      = 5'd17;
   localparam logic [POS_W-1:0] POS_LAST     = 5'd15;
   localparam logic [POS_W-1:0] POS_DASH_A   = 5'd4;
   localparam logic [POS_W-1:0] POS_DASH_B   = 5'd7;
   localparam logic [POS_W-1:0] POS_SLASH    = 5'd10;
   localparam logic [POS_W-1:0] POS_COLON    = 5'd13;
   localparam logic [POS_W-1:0] POS_CENT_LO  = 5'd1;
   localparam logic [POS_W-1:0] POS_YY_HI    = 5'd2;
   localparam logic [POS_W-1:0] POS_YY_LO    = 5'd3;

   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [YEAR_W-1:0] YEAR_MIN   = 14'd1000;
   localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
   localparam logic [ACC_W-1:0]  MONTH_MIN  = 7'd1;
   localparam logic [ACC_W-1:0]  MONTH_MAX  = 7'd12;
   localparam logic [ACC_W-1:0]  DAY_MIN    = 7'd1;
   localparam logic [ACC_W-1:0]  HOUR_MAX   = 7'd23;
   localparam logic [ACC_W-1:0]  MINUTE_MAX = 7'd59;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [DAY_W-1:0]  FEB_LEAP_DAYS = 5'd29;

   // accumulator snapshot taken on the final character
   typedef struct packed {
      logic              ok;        // length 16 and every position well formed
      logic [YEAR_W-1:0] year;
      logic [ACC_W-1:0]  month;
      logic [ACC_W-1:0]  day;
      logic [ACC_W-1:0]  hour;
      logic [ACC_W-1:0]  minute;
      logic [1:0]        cent_mod4; // first two year digits, mod 4
      logic              yy_zero;   // last two year digits are 00
   } snap_type;

   typedef struct packed {
      logic                is_valid;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } result_type;

   // days of a month in a common year, month numbered from 1
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] days;
      case (month)
         4'd2:                      days = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

// File: rtl/tsp_parse.sv
// ----------------------------------------------------------------------------
// tsp_parse
// per-character format check and digit accumulation, state clears after last
// ----------------------------------------------------------------------------
module tsp_parse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [tsp_pkg::CHAR_W-1:0]    char_code,
   input  logic                          last_char,
   output tsp_pkg::snap_type             snap
);

   logic [tsp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        text_ok_ff, text_ok_in;
   logic [tsp_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [tsp_pkg::ACC_W-1:0]   month_ff, month_in;
   logic [tsp_pkg::ACC_W-1:0]   day_ff, day_in;
   logic [tsp_pkg::ACC_W-1:0]   hour_ff, hour_in;
   logic [tsp_pkg::ACC_W-1:0]   minute_ff, minute_in;
   logic [1:0]                  cent_ff, cent_in;
   logic                        yy_zero_ff, yy_zero_in;

   logic                        is_digit;
   logic [tsp_pkg::CHAR_W-1:0]  char_off;
   logic [tsp_pkg::DIGIT_W-1:0] digit;
   logic [tsp_pkg::YEAR_W-1:0]  year_push;
   logic [tsp_pkg::ACC_W-1:0]   acc_sel, acc_push;

   assign is_digit = (char_code >= tsp_pkg::CHAR_ZERO) && (char_code <= tsp_pkg::CHAR_NINE);
   assign char_off = char_code - tsp_pkg::CHAR_ZERO;
   assign digit    = char_off[tsp_pkg::DIGIT_W-1:0];

   // times ten as shift and add
   assign year_push = {year_ff[10:0], 3'b000} + {year_ff[12:0], 1'b0}
                    + {{(tsp_pkg::YEAR_W-tsp_pkg::DIGIT_W){1'b0}}, digit};

   always_comb begin
      if (pos_ff < tsp_pkg::POS_DASH_B) begin
         acc_sel = month_ff;
      end else if (pos_ff < tsp_pkg::POS_SLASH) begin
         acc_sel = day_ff;
      end else if (pos_ff < tsp_pkg::POS_COLON) begin
         acc_sel = hour_ff;
      end else begin
         acc_sel = minute_ff;
      end
   end

   assign acc_push = {acc_sel[3:0], 3'b000} + {acc_sel[5:0], 1'b0}
                   + {{(tsp_pkg::ACC_W-tsp_pkg::DIGIT_W){1'b0}}, digit};

   always_comb begin
      text_ok_in = text_ok_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      cent_in    = cent_ff;
      yy_zero_in = yy_zero_ff;

      if (pos_ff >= tsp_pkg::TEXT_LEN) begin
         text_ok_in = 1'b0;
      end else if (pos_ff == tsp_pkg::POS_DASH_A || pos_ff == tsp_pkg::POS_DASH_B) begin
         if (char_code != tsp_pkg::CHAR_DASH) text_ok_in = 1'b0;
      end else if (pos_ff == tsp_pkg::POS_SLASH) begin
         if (char_code != tsp_pkg::CHAR_SLASH) text_ok_in = 1'b0;
      end else if (pos_ff == tsp_pkg::POS_COLON) begin
         if (char_code != tsp_pkg::CHAR_COLON) text_ok_in = 1'b0;
      end else if (!is_digit) begin
         text_ok_in = 1'b0;
      end else if (pos_ff < tsp_pkg::POS_DASH_A) begin
         year_in = year_push;
         // leap rule tracked per digit: century mod 4 and a zero low pair
         if (pos_ff < tsp_pkg::POS_YY_HI) begin
            cent_in = (pos_ff == tsp_pkg::POS_CENT_LO) ?
                      ({cent_ff[0], 1'b0} + digit[1:0]) : digit[1:0];
         end else begin
            yy_zero_in = ((pos_ff == tsp_pkg::POS_YY_LO) ? yy_zero_ff : 1'b1)
                         && (digit == '0);
         end
      end else if (pos_ff < tsp_pkg::POS_DASH_B) begin
         month_in = acc_push;
      end else if (pos_ff < tsp_pkg::POS_SLASH) begin
         day_in = acc_push;
      end else if (pos_ff < tsp_pkg::POS_COLON) begin
         hour_in = acc_push;
      end else begin
         minute_in = acc_push;
      end

      pos_in = (pos_ff < tsp_pkg::POS_SAT) ? pos_ff + 5'd1 : pos_ff;
   end

   always_comb begin
      snap.ok        = (pos_ff == tsp_pkg::POS_LAST) && text_ok_in;
      snap.year      = year_in;
      snap.month     = month_in;
      snap.day       = day_in;
      snap.hour      = hour_in;
      snap.minute    = minute_in;
      snap.cent_mod4 = cent_in;
      snap.yy_zero   = yy_zero_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_char)) begin
         pos_ff     <= '0;
         text_ok_ff <= 1'b1;
         year_ff    <= '0;
         month_ff   <= '0;
         day_ff     <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         cent_ff    <= '0;
         yy_zero_ff <= 1'b1;
      end else if (accept) begin
         pos_ff     <= pos_in;
         text_ok_ff <= text_ok_in;
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         cent_ff    <= cent_in;
         yy_zero_ff <= yy_zero_in;
      end
   end

endmodule

// File: rtl/tsp_check.sv
// ----------------------------------------------------------------------------
// tsp_check
// calendar range checks on a captured snapshot, fields forced to zero if bad
// ----------------------------------------------------------------------------
module tsp_check (
   input  tsp_pkg::snap_type   snap,
   output tsp_pkg::result_type result
);

   logic                          leap;
   logic [tsp_pkg::DAY_W-1:0]     limit;
   logic                          month_ok;
   logic                          good;

   // with exactly four year digits: divisible by 100 means low pair is 00
   assign leap = snap.yy_zero ? (snap.cent_mod4 == 2'd0) : (snap.year[1:0] == 2'b00);

   assign month_ok = (snap.month >= tsp_pkg::MONTH_MIN) && (snap.month <= tsp_pkg::MONTH_MAX);

   always_comb begin
      limit = tsp_pkg::month_days(snap.month[tsp_pkg::MONTH_W-1:0]);
      if (snap.month[tsp_pkg::MONTH_W-1:0] == tsp_pkg::MONTH_FEB && leap) begin
         limit = tsp_pkg::FEB_LEAP_DAYS;
      end
   end

   assign good = snap.ok
              && (snap.year >= tsp_pkg::YEAR_MIN) && (snap.year <= tsp_pkg::YEAR_MAX)
              && month_ok
              && (snap.day >= tsp_pkg::DAY_MIN)
              && (snap.day <= {{(tsp_pkg::ACC_W-tsp_pkg::DAY_W){1'b0}}, limit})
              && (snap.hour <= tsp_pkg::HOUR_MAX)
              && (snap.minute <= tsp_pkg::MINUTE_MAX);

   always_comb begin
      result = '0;
      if (good) begin
         result.is_valid = 1'b1;
         result.year     = snap.year;
         result.month    = snap.month[tsp_pkg::MONTH_W-1:0];
         result.day      = snap.day[tsp_pkg::DAY_W-1:0];
         result.hour     = snap.hour[tsp_pkg::HOUR_W-1:0];
         result.minute   = snap.minute[tsp_pkg::MINUTE_W-1:0];
      end
   end

endmodule

// File: rtl/timestamp_text_parse_validate.sv
// ----------------------------------------------------------------------------
// timestamp_text_parse_validate
// parses YYYY-MM-DD/HH:MM text one character per transfer and checks the date
// ----------------------------------------------------------------------------
// req channel: one character per transfer in req_tdata[7:0], req_tlast on the
//   final character of a string. one transfer per cycle while req_tready is high
// rsp channel: one transfer per string, issued for the req_tlast character.
//   rsp_tuser is the valid flag; when clear all of rsp_tdata is zero
// pipeline: the final character's accumulators pass the snapshot register,
//   then the result register, which drives rsp_tvalid
// throughput: one character per cycle while req_tready is high, set by the
//   single accumulate stage
// a stalled rsp side holds off the req side only once the snapshot and result
//   registers both hold a finished string; then req_tready drops for every
//   character until the rsp side takes a transfer
// reset: synchronous, clears the parser to the start of a string and drops
//   both pipeline valids; no result is pending afterwards
// any length other than 16 characters gives an invalid (all zero) result
// ----------------------------------------------------------------------------
module timestamp_text_parse_validate (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [13:0] year, [17:14] month, [22:18] day,
                                    // [27:23] hour, [33:28] minute, [39:34] zero
   output logic        rsp_tuser    // is_valid
);

   logic                 accept;
   logic                 out_ready;
   logic                 chk_ready;

   tsp_pkg::snap_type    snap;
   tsp_pkg::snap_type    chk_ff;
   logic                 chk_v_ff, chk_v_in;
   tsp_pkg::result_type  result;
   tsp_pkg::result_type  out_ff;
   logic                 out_v_ff, out_v_in;

   // ready chain back from the receiver
   assign out_ready  = !out_v_ff || rsp_tready;
   assign chk_ready  = !chk_v_ff || out_ready;
   assign req_tready = chk_ready;
   assign accept     = req_tvalid && req_tready;

   // character stage: format check and digit accumulators
   tsp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_tdata),
      .last_char (req_tlast),
      .snap      (snap)
   );

   // snapshot register holds the finished string's accumulators
   always_comb begin
      chk_v_in = chk_v_ff;
      if (accept && req_tlast) begin
         chk_v_in = 1'b1;
      end else if (out_ready) begin
         chk_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_v_ff <= 1'b0;
      end else begin
         chk_v_ff <= chk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         chk_ff <= snap;
      end
   end

   // calendar validation
   tsp_check u_check (
      .snap   (chk_ff),
      .result (result)
   );

   // result register
   assign out_v_in = out_ready ? chk_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && chk_v_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.is_valid;
   assign rsp_tdata  = {6'b000000, out_ff.minute, out_ff.hour, out_ff.day,
                        out_ff.month, out_ff.year};

endmodule
